@@ src/cdx_pkg.sv @@
// Shared types, constants and helpers for the container deframer.
`timescale 1ns / 1ps
`default_nettype none

package cdx_pkg;

    localparam int KEY_DEPTH_DEF = 32;

    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] HDR_SKIP_END = 11'd1116;
    localparam logic [POS_W-1:0] MAGIC_LEN = 11'd4;
    localparam logic [7:0] INVERT_MASK = 8'hff;

    typedef enum logic [3:0] {
        PH_MAGIC,
        PH_SKIP,
        PH_LENGTHS,
        PH_KEY,
        PH_PAYLOAD,
        PH_XOR,
        PH_EMIT_RD,
        PH_EMIT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_KEY      = 2'd1,
        ST_BADMAGIC = 2'd2,
        ST_BADKEY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } res_t;

    // Magic "fxe " in lower case
    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h66;
            2'd1:    c = 8'h78;
            2'd2:    c = 8'h65;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/cdx_key_ram.sv @@
// Key store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cdx_key_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // rdata holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/cdx_ctrl.sv @@
// Parser and sequencer: header walk, length capture, key store access, result build.
`timescale 1ns / 1ps
`default_nettype none

module cdx_ctrl #(
    parameter int KEY_DEPTH = 32,
    parameter int AW        = 5,
    parameter int CW        = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       in_byte,
    input  wire logic             start_req,
    input  wire logic             res_ready,
    output logic                  res_valid,
    output cdx_pkg::res_t         res,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [7:0]            ram_wdata,
    output logic                  ram_re,
    output logic [AW-1:0]         ram_raddr,
    input  wire logic [7:0]       ram_rdata
);

    import cdx_pkg::*;

    localparam logic [31:0] KEY_DEPTH_W = 32'(KEY_DEPTH);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      paylen_reg, paylen_next;
    logic [31:0]      keylen_reg, keylen_next;
    logic [CW-1:0]    kidx_reg, kidx_next;
    logic [CW-1:0]    emit_reg, emit_next;
    logic [7:0]       byte_reg, byte_next;

    phase_t           phase_eff;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] len_off_full;
    logic [2:0]       len_off;
    logic [CW-1:0]    klen;
    logic [CW-1:0]    kidx_inc;
    logic [CW-1:0]    emit_inc;
    logic             busy;
    logic             may_emit;
    logic             in_acc;

    assign phase_eff    = start_req ? PH_MAGIC : phase_reg;
    assign pos_eff      = start_req ? '0 : pos_reg;
    assign pos_inc      = pos_eff + 1'b1;
    assign len_off_full = pos_reg - HDR_SKIP_END;
    assign len_off      = len_off_full[2:0];
    assign klen         = keylen_reg[CW-1:0];
    assign kidx_inc     = kidx_reg + 1'b1;
    assign emit_inc     = emit_reg + 1'b1;

    assign busy = (phase_reg == PH_XOR) || (phase_reg == PH_EMIT_RD)
               || (phase_reg == PH_EMIT);
    // header skip and post-end bytes never produce a result
    assign may_emit = (phase_eff != PH_SKIP) && (phase_eff != PH_DONE);
    assign in_stall = busy || (may_emit && !res_ready);
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        paylen_next = paylen_reg;
        keylen_next = keylen_reg;
        kidx_next   = kidx_reg;
        emit_next   = emit_reg;
        byte_next   = byte_reg;
        ram_we      = 1'b0;
        ram_waddr   = kidx_reg[AW-1:0];
        ram_wdata   = in_byte ^ INVERT_MASK;
        ram_re      = 1'b0;
        ram_raddr   = kidx_reg[AW-1:0];
        res_valid   = 1'b0;
        res.data    = ram_rdata;
        res.status  = ST_PAYLOAD;
        res.last    = 1'b0;

        if (busy)
        begin
            unique case (phase_reg)
                PH_XOR:
                begin
                    res.data = byte_reg ^ ram_rdata;
                    if (res_ready)
                    begin
                        res_valid   = 1'b1;
                        paylen_next = paylen_reg - 1'b1;
                        if (paylen_reg == 32'd1)
                        begin
                            emit_next  = '0;
                            phase_next = PH_EMIT_RD;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_EMIT_RD:
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = emit_reg[AW-1:0];
                    phase_next = PH_EMIT;
                end
                PH_EMIT:
                begin
                    res.status = ST_KEY;
                    res.last   = (emit_inc == klen);
                    if (res_ready)
                    begin
                        res_valid = 1'b1;
                        if (emit_inc == klen)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            // next key byte read overlaps this push
                            emit_next = emit_inc;
                            ram_re    = 1'b1;
                            ram_raddr = emit_inc[AW-1:0];
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
        else if (in_acc)
        begin
            unique case (phase_eff)
                PH_MAGIC:
                begin
                    paylen_next = '0;
                    keylen_next = '0;
                    kidx_next   = '0;
                    if (to_lower(in_byte) != magic_char(pos_eff[1:0]))
                    begin
                        res_valid  = 1'b1;
                        res.data   = '0;
                        res.status = ST_BADMAGIC;
                        res.last   = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        phase_next = (pos_inc == MAGIC_LEN) ? PH_SKIP : PH_MAGIC;
                    end
                end
                PH_SKIP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc == HDR_SKIP_END)
                    begin
                        phase_next = PH_LENGTHS;
                    end
                end
                PH_LENGTHS:
                begin
                    pos_next = pos_inc;
                    // little-endian: payload length then key length
                    if (len_off[2])
                    begin
                        keylen_next[{len_off[1:0], 3'b000} +: 8] = in_byte;
                    end
                    else
                    begin
                        paylen_next[{len_off[1:0], 3'b000} +: 8] = in_byte;
                    end
                    if (len_off == 3'd7)
                    begin
                        if (keylen_next == 32'd0 || keylen_next > KEY_DEPTH_W)
                        begin
                            res_valid  = 1'b1;
                            res.data   = '0;
                            res.status = ST_BADKEY;
                            res.last   = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            kidx_next  = '0;
                            phase_next = PH_KEY;
                        end
                    end
                end
                PH_KEY:
                begin
                    ram_we    = 1'b1;
                    kidx_next = kidx_inc;
                    if (kidx_inc == klen)
                    begin
                        kidx_next = '0;
                        if (paylen_reg == 32'd0)
                        begin
                            emit_next  = '0;
                            phase_next = PH_EMIT_RD;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    byte_next  = in_byte;
                    ram_re     = 1'b1;
                    kidx_next  = (kidx_inc == klen) ? '0 : kidx_inc;
                    phase_next = PH_XOR;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            pos_reg    <= '0;
            paylen_reg <= '0;
            keylen_reg <= '0;
            kidx_reg   <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            paylen_reg <= paylen_next;
            keylen_reg <= keylen_next;
            kidx_reg   <= kidx_next;
            emit_reg   <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

@@ src/container_deframe_xor_decrypt.sv @@
// Top level: container deframer with repeating-key XOR decryption.
//
// Takes a packed executable container one word (byte) at a time. The first
// four bytes must spell "fxe " in either case, the header is skipped up to
// offset 1116, then two little-endian 32-bit lengths (payload, key) are read.
// Key bytes are stored inverted in a KEY_DEPTH-entry synchronous key store;
// each payload byte comes out XORed with the stored key (index wraps at the
// key length), and after the last payload byte the stored key bytes follow,
// the final one flagged by last_out. A bad magic or a key length of zero or
// above KEY_DEPTH yields one result (out_byte 0, status 2 or 3, last_out 1);
// afterwards bytes are swallowed until start_req. The first byte after reset
// is taken as offset 0. Header, length and key bytes are taken one per cycle
// unless stalled; a payload byte is held off until the previous one's key store
// read and XOR push are done. The trailing key dump starts with a key store
// read, then pushes one key byte per cycle while the output is not stalled;
// input is stalled throughout. No clearing pass after reset. A result waiting
// in the output register stalls all input but header-skip and post-end bytes.
`timescale 1ns / 1ps
`default_nettype none

module container_deframe_xor_decrypt #(
    parameter int KEY_DEPTH = cdx_pkg::KEY_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        start_req,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output cdx_pkg::status_t status,
    output logic             last_out
);

    import cdx_pkg::*;

    // address width for the store, counter width able to hold KEY_DEPTH
    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int CW = $clog2(KEY_DEPTH + 1);

    logic          res_ready;
    logic          res_valid;
    res_t          res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_valid_reg, out_valid_next;
    res_t          out_res_reg;

    cdx_ctrl #(
        .KEY_DEPTH (KEY_DEPTH),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .start_req (start_req),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cdx_key_ram #(
        .DEPTH (KEY_DEPTH),
        .AW    (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_res_reg.data;
    assign status    = out_res_reg.status;
    assign last_out  = out_res_reg.last;

    // Key store is never read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("key store read and write in same cycle");

    // Sequencer only offers a result when the output register can take it
    a_res_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result offered while output register is full");

    // Error results carry a zero byte and close the file
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_BADMAGIC || status == ST_BADKEY))
            |-> (out_byte == 8'h00 && last_out))
        else $error("malformed error result");

endmodule

`default_nettype wire
